FILE: hw/rtl/mtr_pkg.sv
// Shared types and constants for the Manchester edge-timing receiver.
`default_nettype none

package mtr_pkg;

	localparam int unsigned TIMEOUT_RESET = 32'd120000;
	localparam int unsigned END_ZERO_RUN  = 16;
	localparam int unsigned ZRUN_W        = 5;

	localparam logic [0:0] REG_TIMEOUT = 1'b0;

	typedef enum logic [2:0] {
		PH_RISE0  = 3'd0,
		PH_FALL1  = 3'd1,
		PH_RISE2  = 3'd2,
		PH_FALL3  = 3'd3,
		PH_RISE4  = 3'd4,
		PH_LOCKED = 3'd5
	} mtr_phase_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       frame_end;
		logic [9:0] frame_bits;
		logic       overflow;
	} mtr_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mtr_core.sv
// Preamble lock, bit window check and byte assembly for one edge per cycle while step is high.
`default_nettype none

module mtr_core
	import mtr_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        level,
	input  wire logic [31:0] edge_time,
	input  wire logic [31:0] timeout_ticks,
	output mtr_result_t      res,
	output logic             res_valid
);

	localparam int unsigned CAP    = MAX_FRAME_BYTES * 8;
	localparam int unsigned CAP_CL = $clog2(CAP + 1);
	localparam int unsigned CAP_W  = (CAP_CL > 10) ? CAP_CL : 10;

	mtr_phase_t        phase_q, phase_d;
	logic [31:0]       last_q, last_d;
	logic [31:0]       prior_q, prior_d;
	logic [31:0]       period_q, period_d;
	logic [7:0]        shift_q, shift_d;
	logic [2:0]        pos_q, pos_d;
	logic [ZRUN_W-1:0] zrun_q, zrun_d;
	logic [CAP_W-1:0]  total_q, total_d;
	logic              ovf_q, ovf_d;

	logic [31:0]       gap;
	logic              match;
	logic              timed_out;
	logic [32:0]       avg_sum;
	logic [32:0]       diff;
	logic [31:0]       mag;
	logic [33:0]       mag3;
	logic              in_win;
	logic [ZRUN_W-1:0] zrun_inc;
	logic              ended;

	assign gap       = edge_time - last_q;
	assign match     = (level != phase_q[0]);
	assign timed_out = (gap > timeout_ticks);
	assign avg_sum   = {1'b0, prior_q} + {1'b0, gap};

	// |gap - period| <= floor(period / 3)  <=>  3 * |gap - period| <= period
	assign diff   = {1'b0, gap} - {1'b0, period_q};
	assign mag    = diff[32] ? 32'(-diff) : diff[31:0];
	assign mag3   = {2'b00, mag} + {1'b0, mag, 1'b0};
	assign in_win = (mag3 <= {2'b00, period_q});

	assign zrun_inc = level ? '0 :
		((zrun_q < ZRUN_W'(END_ZERO_RUN)) ? ZRUN_W'(zrun_q + 1'b1) : zrun_q);
	assign ended    = (zrun_inc >= ZRUN_W'(END_ZERO_RUN));

	always_comb begin
		phase_d = phase_q;
		if (step) begin
			case (phase_q)
				PH_LOCKED: begin
					if (in_win && ended)
						phase_d = PH_RISE0;
				end
				PH_RISE0: begin
					if (match)
						phase_d = PH_FALL1;
				end
				default: begin
					if (match)
						phase_d = timed_out ? PH_RISE0 : mtr_phase_t'(3'(phase_q + 3'd1));
				end
			endcase
		end
	end

	always_comb begin
		logic got;
		got       = 1'b0;
		last_d    = last_q;
		prior_d   = prior_q;
		period_d  = period_q;
		shift_d   = shift_q;
		pos_d     = pos_q;
		zrun_d    = zrun_q;
		total_d   = total_q;
		ovf_d     = ovf_q;
		res       = '0;
		res_valid = 1'b0;
		if (step) begin
			if (phase_q != PH_LOCKED) begin
				if (match) begin
					last_d = edge_time;
					if (phase_q == PH_FALL3)
						prior_d = gap;
					if (phase_q == PH_RISE4)
						period_d = avg_sum[32:1];
				end
			end else if (in_win) begin
				last_d = edge_time;
				if (total_q < CAP_W'(CAP)) begin
					total_d = CAP_W'(total_q + 1'b1);
					shift_d = {shift_q[6:0], level};
					pos_d   = 3'(pos_q + 3'd1);
					got     = (pos_q == 3'd7);
				end else begin
					ovf_d = 1'b1;
				end
				zrun_d         = zrun_inc;
				res.byte_valid = got;
				res.data_byte  = got ? shift_d : 8'd0;
				res.frame_end  = ended;
				res.frame_bits = total_d[9:0];
				res.overflow   = ovf_d;
				res_valid      = got | ended;
				if (ended) begin
					shift_d = '0;
					pos_d   = '0;
					zrun_d  = '0;
					total_d = '0;
					ovf_d   = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RISE0;
			last_q   <= '0;
			prior_q  <= '0;
			period_q <= '0;
			shift_q  <= '0;
			pos_q    <= '0;
			zrun_q   <= '0;
			total_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			last_q   <= last_d;
			prior_q  <= prior_d;
			period_q <= period_d;
			shift_q  <= shift_d;
			pos_q    <= pos_d;
			zrun_q   <= zrun_d;
			total_q  <= total_d;
			ovf_q    <= ovf_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/manchester_edge_timing_receiver.sv
// An edge beat is registered at the input; its result is registered again for the master side.
// Throughput: one edge beat per cycle while the master side keeps taking results.
// The receive state updates as an edge leaves the input register, when the result register loads.
// Reset: asynchronous, active low; clears lock, period, frame state and sets the timeout
// register to 120000 ticks.
// Edges that cause no result still pass through the input register.
`default_nettype none

module manchester_edge_timing_receiver
	import mtr_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tdata: [0] level, [32:1] edge_time, [39:33] zero
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	// tdata: [7:0] data_byte, [17:8] frame_bits, [18] overflow, [23:19] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,
	// tuser: [0] byte_valid
	output logic             m_axis_tuser,
	// tlast: frame_end
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        vld_s1;
	logic        lvl_s1;
	logic [31:0] time_s1;
	logic        go;
	logic        out_vld_q;
	mtr_result_t res_q;
	mtr_result_t res;
	logic        res_valid;
	logic [31:0] timeout_q;
	logic        reg_hit;

	assign go            = vld_s1 & (~out_vld_q | m_axis_tready);
	assign s_axis_tready = ~vld_s1 | go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lvl_s1  <= s_axis_tdata[0];
			time_s1 <= s_axis_tdata[32:1];
		end
	end

	mtr_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (go),
		.level        (lvl_s1),
		.edge_time    (time_s1),
		.timeout_ticks(timeout_q),
		.res          (res),
		.res_valid    (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go && res_valid) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid)
			res_q <= res;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, res_q.overflow, res_q.frame_bits, res_q.data_byte};
	assign m_axis_tuser  = res_q.byte_valid;
	assign m_axis_tlast  = res_q.frame_end;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_TIMEOUT) && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata;
		end
	end

	assign prdata = reg_hit ? timeout_q : 32'd0;

endmodule

`default_nettype wire

FILE: hw/rtl/mtr_checker.sv
// Port-level checks on result beats of the receiver, bound to the top level.
`default_nettype none

module mtr_checker #(
	parameter int unsigned MAX_FRAME_BYTES = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);

	localparam int unsigned CAP = MAX_FRAME_BYTES * 8;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser || m_axis_tlast)
		else $error("result beat with neither byte nor frame end");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
		else $error("data byte nonzero without a completed byte");

	a_byte_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:8] == 3'd0)
		else $error("completed byte at a bit count not a multiple of eight");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (CAP >= 1024) || (32'(m_axis_tdata[17:8]) <= CAP))
		else $error("frame bit count above capacity");

endmodule

bind manchester_edge_timing_receiver mtr_checker #(
	.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
) u_mtr_checker (.*);

`default_nettype wire

FILE: tb/mtr_frame_checker.sv
// Checker for the Manchester receiver: predicts decoded beats and compares them.
`timescale 1ns / 100ps

module mtr_frame_checker
	import mtr_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	// tdata: [0] level, [32:1] edge_time, [39:33] zero
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: [7:0] data_byte, [17:8] frame_bits, [18] overflow, [23:19] zero
	input  wire logic [23:0] m_axis_tdata,
	// tuser: [0] byte_valid
	input  wire logic        m_axis_tuser,
	input  wire logic        m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               errors,
	output int               reports_due
);

	localparam int unsigned CAPACITY     = MAX_FRAME_BYTES * 8;
	localparam logic [2:0]  TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

	mtr_phase_t          phase;
	logic [31:0]         timeout;
	logic [31:0]         last_time;
	logic [31:0]         prior_iv;
	logic [31:0]         period;
	logic [7:0]          shift;
	logic [2:0]          bitpos;
	logic [ZRUN_W-1:0]   zrun;
	int unsigned         total;
	logic                ovf;
	mtr_result_t         byte_reports[$];

	function automatic void clear_frame();
		shift  = '0;
		bitpos = '0;
		zrun   = '0;
		total  = 0;
		ovf    = 1'b0;
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			errors++;
		end
	endfunction

	function automatic void decode_edge(input logic lvl, input logic [31:0] t);
		logic [31:0] gap;
		logic [32:0] third;
		logic [32:0] lo;
		logic [32:0] hi;
		mtr_result_t rep;
		gap = t - last_time;
		rep = '0;
		if (phase != PH_LOCKED) begin
			// drop edges of the wrong level for this preamble step
			if (lvl == phase[0])
				return;
			if (phase == PH_FALL3)
				prior_iv = gap;
			if (phase == PH_RISE4)
				period = 32'(({1'b0, prior_iv} + {1'b0, gap}) >> 1);
			if (phase != PH_RISE0 && gap > timeout)
				phase = PH_RISE0;
			else
				phase = mtr_phase_t'(phase + 3'd1);
			last_time = t;
			return;
		end
		third = 33'(period / 3);
		lo = {1'b0, period} - third;
		hi = {1'b0, period} + third;
		if ({1'b0, gap} < lo || {1'b0, gap} > hi)
			return;
		last_time = t;
		if (total < CAPACITY) begin
			total++;
			shift  = {shift[6:0], lvl};
			bitpos = bitpos + 3'd1;
			if (bitpos == 3'd0) begin
				rep.byte_valid = 1'b1;
				rep.data_byte  = shift;
			end
		end else begin
			ovf = 1'b1;
		end
		if (lvl)
			zrun = '0;
		else if (zrun < END_ZERO_RUN)
			zrun++;
		rep.frame_end = (zrun >= END_ZERO_RUN);
		if (!(rep.byte_valid || rep.frame_end))
			return;
		rep.frame_bits = total[9:0];
		rep.overflow   = ovf;
		byte_reports.push_back(rep);
		if (rep.frame_end) begin
			clear_frame();
			phase = PH_RISE0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mtr_result_t rep;
		if (!arst_n) begin
			phase     = PH_RISE0;
			timeout   = TIMEOUT_RESET;
			last_time = '0;
			prior_iv  = '0;
			period    = '0;
			clear_frame();
			byte_reports.delete();
			errors      = 0;
			reports_due = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (byte_reports.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual 0x%0h",
						$time, {m_axis_tlast, m_axis_tuser, m_axis_tdata});
					errors++;
				end else begin
					rep = byte_reports.pop_front();
					check_field("byte_valid", rep.byte_valid, m_axis_tuser);
					check_field("data_byte", rep.data_byte, m_axis_tdata[7:0]);
					check_field("frame_end", rep.frame_end, m_axis_tlast);
					check_field("frame_bits", rep.frame_bits, m_axis_tdata[17:8]);
					check_field("overflow", rep.overflow, m_axis_tdata[18]);
				end
			end
			if (psel && penable && pready && paddr == TIMEOUT_ADDR) begin
				if (pwrite)
					timeout = pwdata;
				else
					check_field("prdata", timeout, prdata);
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_edge(s_axis_tdata[0], s_axis_tdata[32:1]);
			reports_due = byte_reports.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// Top of the Manchester receiver testbench: clock, reset, edge stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import mtr_pkg::*;

	localparam int unsigned FRAME_BYTES  = 64;
	localparam logic [2:0]  TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          reports_due;

	bit          idle_on;
	int          sent;
	logic [31:0] now;
	logic [31:0] timeout_cur;
	logic [31:0] cur_period;

	manchester_edge_timing_receiver #(.MAX_FRAME_BYTES(FRAME_BYTES)) uut (.*);

	mtr_frame_checker #(.MAX_FRAME_BYTES(FRAME_BYTES)) u_frame_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_edge(input logic lvl, input logic [31:0] t, input bit counted);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, t, lvl};
		do @(posedge clk); while (!s_axis_tready);
		if (counted)
			sent++;
	endtask

	task automatic step_edge(input logic lvl, input logic [31:0] gap);
		now = now + gap;
		send_edge(lvl, now, 1'b1);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= TIMEOUT_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [31:0] value);
		drain();
		apb_access(1'b1, value);
		apb_access(1'b0, 32'd0);
		timeout_cur = value;
	endtask

	function automatic logic [31:0] pick_base();
		logic [31:0] lim;
		if (timeout_cur == 0)
			return 32'd0;
		lim = (timeout_cur < 4000) ? timeout_cur : 32'd4000;
		if ($urandom_range(0, 3) == 0 && lim > 6)
			lim = 6;
		return $urandom_range(1, lim);
	endfunction

	function automatic logic [31:0] near_gap(input logic [31:0] base, input bit huge);
		longint unsigned j;
		longint unsigned g;
		if (huge)
			return 32'hF000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
		j = base / 16;
		g = base - j + $urandom_range(0, 32'(2 * j));
		if (g > timeout_cur)
			g = timeout_cur;
		return g[31:0];
	endfunction

	task automatic run_preamble(input logic [31:0] base, input bit huge);
		logic [31:0] g;
		logic [31:0] g3;
		int          brk;
		int          i;
		bit          done;
		brk = 0;
		if (timeout_cur != 32'hFFFF_FFFF && $urandom_range(0, 7) == 0)
			brk = $urandom_range(1, 4);
		done = 1'b0;
		g3 = '0;
		while (!done) begin
			step_edge(1'b1, $urandom);
			done = 1'b1;
			for (i = 1; i < 5 && done; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_edge(i[0], now + $urandom, 1'b0);
				if (i == brk) begin
					// overrun the timeout, then restart the preamble
					g = timeout_cur + 32'd1 + (($urandom_range(0, 3) == 0) ?
						$urandom_range(0, ~timeout_cur - 32'd1) : 32'd0);
					brk  = 0;
					done = 1'b0;
				end else begin
					g = near_gap(base, huge);
				end
				step_edge(~i[0], g);
				if (i == 3)
					g3 = g;
				if (i == 4)
					cur_period = 32'(({1'b0, g3} + {1'b0, g}) >> 1);
			end
		end
	endtask

	task automatic data_edge(input logic lvl);
		logic [32:0] third;
		logic [32:0] lo;
		logic [32:0] hi;
		logic [31:0] g;
		third = 33'(cur_period / 3);
		lo = {1'b0, cur_period} - third;
		hi = {1'b0, cur_period} + third;
		if (hi[32])
			hi = 33'h0_FFFF_FFFF;
		if ($urandom_range(0, 15) == 0) begin
			if (lo != 0 && ($urandom_range(0, 1) == 0 || hi[31:0] == 32'hFFFF_FFFF))
				send_edge(1'($urandom_range(0, 1)), now + lo[31:0] - 32'd1, 1'b0);
			else if (hi[31:0] != 32'hFFFF_FFFF)
				send_edge(1'($urandom_range(0, 1)), now + hi[31:0] + 32'd1, 1'b0);
		end
		case ($urandom_range(0, 7))
			0: begin
				g = lo[31:0];
			end
			1: begin
				g = hi[31:0];
			end
			default: begin
				g = lo[31:0] + $urandom_range(0, hi[31:0] - lo[31:0]);
			end
		endcase
		step_edge(lvl, g);
	endtask

	task automatic run_frame(input int nbits, input bit huge);
		int   style;
		int   zeros;
		logic b;
		run_preamble(huge ? 32'd0 : pick_base(), huge);
		style = $urandom_range(0, 7);
		zeros = 0;
		repeat (nbits) begin
			b = (style == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			// hold the frame open until the terminating run
			if (!b && zeros == 15)
				b = 1'b1;
			zeros = b ? 0 : zeros + 1;
			data_edge(b);
		end
		repeat (16 - zeros) data_edge(1'b0);
	endtask

	task automatic run_frames(input int goal);
		while (sent < goal)
			run_frame($urandom_range(0, 1) ? 8 * $urandom_range(0, 5) : $urandom_range(0, 40),
				1'b0);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		idle_on       = 1'b1;
		sent          = 0;
		now           = 32'hFFFF_FFC0;
		timeout_cur   = TIMEOUT_RESET;
		cur_period    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, 32'd0);

		send_edge(1'b0, now, 1'b0);
		step_edge(1'b1, 32'd0);
		step_edge(1'b0, 32'd40);
		send_edge(1'b0, now + 32'd7, 1'b0);
		step_edge(1'b1, 32'd40);
		step_edge(1'b0, 32'd41);
		step_edge(1'b1, 32'd39);
		cur_period = 32'd40;
		step_edge(1'b1, 32'd27);
		step_edge(1'b1, 32'd53);
		send_edge(1'b1, now + 32'd26, 1'b0);
		send_edge(1'b0, now + 32'd54, 1'b0);
		repeat (16) step_edge(1'b0, 32'd40);
		run_frames(40);

		set_timeout(32'hFFFF_FFFF);
		repeat (2) run_frame($urandom_range(8, 24), 1'b1);
		run_frame(530, 1'b0);
		run_frames(sent + 10);

		set_timeout(32'd0);
		run_frames(sent + 10);

		set_timeout($urandom);
		run_frames(sent + 10);

		set_timeout($urandom_range(50, 3000));
		run_frames(sent + 10);

		set_timeout(TIMEOUT_RESET);
		idle_on = 1'b0;
		run_frames(sent + 10);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
